// ----- hdl/fmibs_pkg.sv -----
`timescale 1ns / 1ps

package fmibs_pkg;

  // Command codes carried on the input tuser
  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_FIRST  = 2'd2,
    CMD_NEXT   = 2'd3
  } cmd_t;

  // Symbol codes
  localparam logic [2:0] SYM_END = 3'd0;  // '$'
  localparam logic [2:0] SYM_A   = 3'd1;
  localparam logic [2:0] SYM_T   = 3'd4;

  localparam int unsigned NUM_SYMS = 5;

  // Result field widths
  localparam int unsigned LOWER_W = 13;
  localparam int unsigned UPPER_W = 14;

endpackage

// ----- hdl/fm_index_backward_search_unit.sv -----
`timescale 1ns / 1ps

// Channel | Dir | Fields (low bit up)                                   | Transfer when
// in_     | in  | tdata: symbol[2:0]; tuser: cmd[1:0]                   | in_tvalid & in_tready
// out_    | out | tdata: lower_bound[12:0], upper_bound[26:13] (signed), | out_tvalid & out_tready
//         |     |        is_empty[27], is_invalid[28]                   |
//
// Clear and append give no result. A first query symbol sums the totals of the
// smaller symbols, one per cycle. A next query symbol on a search that has not
// stopped also scans a prefix of the stored transform (at most the stored length),
// read one entry per cycle from the single transform RAM.
// rst_n is synchronous; it clears the stored length and totals, not the transform RAM.
// in_tready is low while a query is worked on, and while its finished result waits
// for the previous result to leave the output register.

module fm_index_backward_search_unit
  import fmibs_pkg::*;
#(
  parameter int BWT_DEPTH = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // symbol[2:0], zero pad
  input  logic [1:0]  in_tuser,   // cmd[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata   // lower_bound, upper_bound, is_empty, is_invalid, pad
);

  localparam int AW = $clog2(BWT_DEPTH);
  localparam int LW = $clog2(BWT_DEPTH + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREFIX,
    ST_LIMIT,
    ST_RANGE,
    ST_SCAN,
    ST_EMIT
  } state_t;

  state_t               state_r, state_nxt;
  cmd_t                 cmd_r, cmd_nxt;
  logic [2:0]           sym_r, sym_nxt;
  logic [LW-1:0]        len_r, len_nxt;
  logic [LW-1:0]        totals_r [NUM_SYMS];
  logic [LW-1:0]        totals_nxt [NUM_SYMS];
  logic [LW-1:0]        low_r, low_nxt;
  logic signed [LW:0]   high_r, high_nxt;
  logic                 stopped_r, stopped_nxt;
  logic                 bad_r, bad_nxt;
  logic [2:0]           k_r, k_nxt;
  logic [LW-1:0]        acc_r, acc_nxt;
  logic [LW-1:0]        lim_lo_r, lim_lo_nxt;
  logic [LW-1:0]        lim_hi_r, lim_hi_nxt;
  logic [LW-1:0]        end_r, end_nxt;
  logic [LW-1:0]        idx_r, idx_nxt;
  logic                 pend_r, pend_nxt;
  logic [LW-1:0]        pend_idx_r, pend_idx_nxt;
  logic [LW-1:0]        occ_lo_r, occ_lo_nxt;
  logic [LW-1:0]        occ_hi_r, occ_hi_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [31:0]          out_data_r, out_data_nxt;

  logic                 in_xfer;
  cmd_t                 in_cmd;
  logic [2:0]           in_sym;
  logic                 sym_acgt;
  logic                 ram_we;
  logic                 ram_re;
  logic [AW-1:0]        ram_raddr;
  logic [2:0]           ram_rdata;
  logic signed [LW:0]   high_p1;
  logic                 empty;
  logic [LOWER_W-1:0]   lower_out;
  logic [UPPER_W-1:0]   upper_out;

  assign in_cmd    = cmd_t'(in_tuser);
  assign in_sym    = in_tdata[2:0];
  assign in_tready = (state_r == ST_IDLE);
  assign in_xfer   = in_tvalid && in_tready;
  assign sym_acgt  = (sym_r >= SYM_A) && (sym_r <= SYM_T);

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Append of a symbol code up to T writes the next free entry of the transform store while it has room
  assign ram_we = in_xfer && (in_cmd == CMD_APPEND) && (in_sym <= SYM_T) &&
                  (len_r < LW'(BWT_DEPTH));

  fmibs_ram #(
    .WIDTH (3),
    .DEPTH (BWT_DEPTH)
  ) u_bwt_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (len_r[AW-1:0]),
    .wr_data (in_sym),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  assign high_p1   = high_r + (LW+1)'(1);
  assign empty     = bad_r || ($signed({1'b0, low_r}) > high_r);
  assign lower_out = LOWER_W'(low_r);
  assign upper_out = UPPER_W'(high_r);

  // Sequencer next-state logic
  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    sym_nxt       = sym_r;
    len_nxt       = len_r;
    totals_nxt    = totals_r;
    low_nxt       = low_r;
    high_nxt      = high_r;
    stopped_nxt   = stopped_r;
    bad_nxt       = bad_r;
    k_nxt         = k_r;
    acc_nxt       = acc_r;
    lim_lo_nxt    = lim_lo_r;
    lim_hi_nxt    = lim_hi_r;
    end_nxt       = end_r;
    idx_nxt       = idx_r;
    pend_nxt      = 1'b0;
    pend_idx_nxt  = pend_idx_r;
    occ_lo_nxt    = occ_lo_r;
    occ_hi_nxt    = occ_hi_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    ram_re        = 1'b0;
    ram_raddr     = idx_r[AW-1:0];

    // Drop the result once the sink takes it
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          cmd_nxt = in_cmd;
          sym_nxt = in_sym;
          k_nxt   = '0;
          acc_nxt = '0;
          unique case (in_cmd)
            CMD_CLEAR: begin
              len_nxt = '0;
              for (int s = 0; s < NUM_SYMS; s++) begin
                totals_nxt[s] = '0;
              end
            end
            CMD_APPEND: begin
              if (ram_we) begin
                len_nxt = len_r + LW'(1);
                totals_nxt[in_sym] = totals_r[in_sym] + LW'(1);
              end
            end
            CMD_FIRST: begin
              state_nxt = ST_PREFIX;
            end
            CMD_NEXT: begin
              state_nxt = stopped_r ? ST_EMIT : ST_PREFIX;
            end
            default: ;
          endcase
        end
      end

      // Sum the totals of smaller symbols, one per cycle
      ST_PREFIX: begin
        if (!sym_acgt) begin
          bad_nxt     = 1'b1;
          stopped_nxt = 1'b1;
          if (cmd_r == CMD_FIRST) begin
            low_nxt  = '0;
            high_nxt = -(LW+1)'(1);
          end
          state_nxt = ST_EMIT;
        end else if (k_r != sym_r) begin
          acc_nxt = acc_r + totals_r[k_r];
          k_nxt   = k_r + 3'd1;
        end else if (cmd_r == CMD_FIRST) begin
          bad_nxt     = 1'b0;
          low_nxt     = acc_r;
          high_nxt    = $signed({1'b0, acc_r}) + $signed({1'b0, totals_r[k_r]}) -
                        (LW+1)'(1);
          stopped_nxt = (totals_r[k_r] == '0);
          state_nxt   = ST_EMIT;
        end else begin
          state_nxt = ST_LIMIT;
        end
      end

      // Clamp both scan limits to the stored length
      ST_LIMIT: begin
        lim_lo_nxt = (low_r > len_r) ? len_r : low_r;
        if (high_r[LW]) begin
          lim_hi_nxt = '0;
        end else begin
          lim_hi_nxt = (high_p1[LW-1:0] > len_r) ? len_r : high_p1[LW-1:0];
        end
        state_nxt = ST_RANGE;
      end

      // Scan up to the larger limit
      ST_RANGE: begin
        end_nxt    = (lim_lo_r > lim_hi_r) ? lim_lo_r : lim_hi_r;
        idx_nxt    = '0;
        occ_lo_nxt = '0;
        occ_hi_nxt = '0;
        state_nxt  = ST_SCAN;
      end

      // Issue one read per cycle, count matches in the cycle after each read
      ST_SCAN: begin
        if (idx_r < end_r) begin
          ram_re       = 1'b1;
          pend_nxt     = 1'b1;
          pend_idx_nxt = idx_r;
          idx_nxt      = idx_r + LW'(1);
        end
        if (pend_r && (ram_rdata == sym_r)) begin
          if (pend_idx_r < lim_lo_r) begin
            occ_lo_nxt = occ_lo_r + LW'(1);
          end
          if (pend_idx_r < lim_hi_r) begin
            occ_hi_nxt = occ_hi_r + LW'(1);
          end
        end
        if (!(idx_r < end_r) && !pend_r) begin
          low_nxt     = acc_r + occ_lo_r;
          high_nxt    = $signed({1'b0, acc_r}) + $signed({1'b0, occ_hi_r}) -
                        (LW+1)'(1);
          stopped_nxt = (occ_lo_r >= occ_hi_r);
          state_nxt   = ST_EMIT;
        end
      end

      // Load the output register once it is free
      ST_EMIT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {3'b000, bad_r, empty, upper_out, lower_out};
          state_nxt     = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  // Hold state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      len_r       <= '0;
      for (int s = 0; s < NUM_SYMS; s++) begin
        totals_r[s] <= '0;
      end
      low_r       <= '0;
      high_r      <= '0;
      stopped_r   <= 1'b0;
      bad_r       <= 1'b0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      len_r       <= len_nxt;
      totals_r    <= totals_nxt;
      low_r       <= low_nxt;
      high_r      <= high_nxt;
      stopped_r   <= stopped_nxt;
      bad_r       <= bad_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cmd_r      <= cmd_nxt;
    sym_r      <= sym_nxt;
    k_r        <= k_nxt;
    acc_r      <= acc_nxt;
    lim_lo_r   <= lim_lo_nxt;
    lim_hi_r   <= lim_hi_nxt;
    end_r      <= end_nxt;
    idx_r      <= idx_nxt;
    pend_idx_r <= pend_idx_nxt;
    occ_lo_r   <= occ_lo_nxt;
    occ_hi_r   <= occ_hi_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

// ----- hdl/fmibs_ram.sv -----
`timescale 1ns / 1ps

module fmibs_ram #(
  parameter int WIDTH = 3,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 1ps

module tb;
  import fmibs_pkg::*;

  localparam int DEPTH       = 4096;
  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int RAND_ITEMS  = 140;
  localparam int TAIL_CYCLES = 32;

  // Symbol codes the package does not name
  localparam logic [2:0] SYM_C     = 3'd2;
  localparam logic [2:0] SYM_G     = 3'd3;
  localparam logic [2:0] SYM_INV_5 = 3'd5;
  localparam logic [2:0] SYM_INV_6 = 3'd6;
  localparam logic [2:0] SYM_INV_7 = 3'd7;

  typedef struct {
    cmd_t       cmd;
    logic [2:0] sym;
    bit         drain;  // hold off until every interval has come back
  } search_item_t;

  typedef struct {
    logic [LOWER_W-1:0] lower;
    logic [UPPER_W-1:0] upper;
    logic               empty;
    logic               invalid;
  } interval_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;   // symbol[2:0], zero pad
  logic [1:0]  in_tuser = '0;   // cmd[1:0]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;       // lower[12:0], upper[26:13], empty[27], invalid[28]

  fm_index_backward_search_unit #(.BWT_DEPTH(DEPTH)) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always #6 clk = ~clk;

  search_item_t cmd_q[$];
  interval_t    interval_q[$];
  search_item_t in_item;
  interval_t    want;
  bit           failed = 1'b0;
  bit           in_done = 1'b0;
  bit           out_done = 1'b0;
  bit           in_burst = 1'b0;
  bit           out_burst = 1'b0;
  int           in_gap = 0;
  int           out_gap = 0;
  int           cycles = 0;

  // Shadow of the search state
  logic [2:0] bwt_mem [DEPTH];
  int         bwt_len = 0;
  int         sym_total [NUM_SYMS] = '{default: 0};
  int         iv_low = 0;
  int         iv_high = 0;
  bit         q_stopped = 1'b0;
  bit         q_bad = 1'b0;

  // Count of stored symbols that sort below s
  function automatic int rank_below(logic [2:0] s);
    int sum = 0;
    for (int k = 0; k < NUM_SYMS; k++)
      if (k < int'(s)) sum += sym_total[k];
    return sum;
  endfunction

  // Occurrences of s at rows 0..pos, clipped to the stored length
  function automatic int occ_through(logic [2:0] s, int pos);
    int n = 0;
    int stop;
    if (pos < 0) return 0;
    stop = (pos + 1 > bwt_len) ? bwt_len : pos + 1;
    for (int i = 0; i < stop; i++)
      if (bwt_mem[i] == s) n++;
    return n;
  endfunction

  // Advance the shadow state by one accepted item, queue the interval it reports
  task automatic search_step(search_item_t it);
    bit        acgt;
    int        base;
    int        lo;
    int        hi;
    interval_t r;
    acgt = (it.sym >= SYM_A) && (it.sym <= SYM_T);
    case (it.cmd)
      CMD_CLEAR: begin
        bwt_len = 0;
        for (int k = 0; k < NUM_SYMS; k++) sym_total[k] = 0;
      end
      CMD_APPEND: begin
        if (it.sym < NUM_SYMS && bwt_len < DEPTH) begin
          bwt_mem[bwt_len] = it.sym;
          bwt_len++;
          sym_total[it.sym]++;
        end
      end
      CMD_FIRST: begin
        q_bad = 1'b0;
        q_stopped = 1'b0;
        if (!acgt) begin
          q_bad = 1'b1;
          q_stopped = 1'b1;
          iv_low = 0;
          iv_high = -1;
        end else begin
          base = rank_below(it.sym);
          iv_low = base;
          iv_high = base + sym_total[it.sym] - 1;
          if (iv_low > iv_high) q_stopped = 1'b1;
        end
      end
      default: begin
        if (!q_stopped) begin
          if (!acgt) begin
            q_bad = 1'b1;
            q_stopped = 1'b1;
          end else begin
            base = rank_below(it.sym);
            lo = base + occ_through(it.sym, iv_low - 1);
            hi = base + occ_through(it.sym, iv_high) - 1;
            iv_low = lo;
            iv_high = hi;
            if (lo > hi) q_stopped = 1'b1;
          end
        end
      end
    endcase
    if (it.cmd == CMD_FIRST || it.cmd == CMD_NEXT) begin
      r.lower = LOWER_W'(iv_low);
      r.upper = UPPER_W'(iv_high);
      r.empty = q_bad || (iv_low > iv_high);
      r.invalid = q_bad;
      interval_q = {interval_q, r};
    end
  endtask

  task automatic check_field(string name, logic [UPPER_W-1:0] exp_v, logic [UPPER_W-1:0] got_v);
    if (got_v !== exp_v) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, got_v);
      failed = 1'b1;
    end
  endtask

  // Sample both channels at the rising edge
  always @(posedge clk) begin
    if (rst_n) begin
      in_done <= in_tvalid && in_tready;
      out_done <= out_tvalid && out_tready;
      if (in_tvalid && in_tready) search_step(in_item);
      if (out_tvalid && out_tready) begin
        if (interval_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $time, out_tdata);
          failed = 1'b1;
        end else begin
          want = interval_q.pop_front();
          check_field("lower_bound", UPPER_W'(want.lower), UPPER_W'(out_tdata[12:0]));
          check_field("upper_bound", want.upper, out_tdata[26:13]);
          check_field("is_empty", UPPER_W'(want.empty), UPPER_W'(out_tdata[27]));
          check_field("is_invalid", UPPER_W'(want.invalid), UPPER_W'(out_tdata[28]));
        end
      end
    end
  end

  // Drive the next pending item once the current transfer is done
  always @(negedge clk) begin
    if (rst_n && !(in_tvalid && !in_done)) begin
      if (in_gap > 0) begin
        in_gap--;
        in_tvalid <= 1'b0;
      end else if (cmd_q.size() != 0 && !(cmd_q[0].drain && interval_q.size() != 0)) begin
        in_item = cmd_q.pop_front();
        in_tdata <= {5'b0, in_item.sym};
        in_tuser <= in_item.cmd;
        in_tvalid <= 1'b1;
        if ($urandom_range(0, 19) == 0) in_burst = !in_burst;
        in_gap = in_burst ? 0 : $urandom_range(0, 5);
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Stall the result side for a random stretch after each transfer
  always @(negedge clk) begin
    if (rst_n) begin
      if (out_done) begin
        if ($urandom_range(0, 9) == 0) out_burst = !out_burst;
        out_gap = out_burst ? 0 : $urandom_range(0, 5);
      end
      if (out_gap > 0) begin
        out_gap--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Guard against a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic put(cmd_t c, logic [2:0] s, bit d = 1'b0);
    search_item_t it;
    it.cmd = c;
    it.sym = s;
    it.drain = d;
    cmd_q = {cmd_q, it};
  endtask

  function automatic logic [2:0] store_sym();
    int r;
    r = $urandom_range(0, 15);
    if (r == 0) return 3'($urandom_range(SYM_INV_5, SYM_INV_7));
    if (r == 1) return SYM_END;
    return 3'($urandom_range(SYM_A, SYM_T));
  endfunction

  function automatic logic [2:0] query_sym();
    int r;
    r = $urandom_range(0, 23);
    if (r == 0) return SYM_END;
    if (r == 1) return 3'($urandom_range(SYM_INV_5, SYM_INV_7));
    return 3'($urandom_range(SYM_A, SYM_T));
  endfunction

  initial begin
    int counted;
    logic [2:0] s;

    // Directed: step before any first symbol, empty store, ignored appends
    put(CMD_NEXT, SYM_A);
    put(CMD_FIRST, SYM_A);
    put(CMD_APPEND, SYM_INV_5);
    put(CMD_APPEND, SYM_INV_6);
    put(CMD_APPEND, SYM_INV_7);
    put(CMD_APPEND, SYM_A);
    put(CMD_APPEND, SYM_C);
    put(CMD_APPEND, SYM_END);
    put(CMD_APPEND, SYM_G);
    put(CMD_APPEND, SYM_T);
    put(CMD_APPEND, SYM_A);
    put(CMD_APPEND, SYM_A);
    // Ordinary search, then an invalid step and a step after the stop
    put(CMD_FIRST, SYM_A);
    put(CMD_NEXT, SYM_A);
    put(CMD_NEXT, SYM_T);
    put(CMD_FIRST, SYM_G);
    put(CMD_NEXT, SYM_INV_7);
    put(CMD_NEXT, SYM_C);
    // Invalid first symbols
    put(CMD_FIRST, SYM_END);
    put(CMD_FIRST, SYM_INV_6);
    // Clear keeps the interval; the next step reaches past the short store
    put(CMD_FIRST, SYM_T);
    put(CMD_CLEAR, SYM_T, 1'b1);
    put(CMD_APPEND, SYM_C);
    put(CMD_NEXT, SYM_C);
    put(CMD_NEXT, SYM_INV_5);

    // Random: short stores followed by backward searches
    counted = 0;
    while (counted < RAND_ITEMS) begin
      if ($urandom_range(0, 3) != 0) begin
        put(CMD_CLEAR, 3'($urandom_range(0, 7)), $urandom_range(0, 5) == 0);
        counted++;
      end
      repeat ($urandom_range(1, 20)) begin
        s = store_sym();
        put(CMD_APPEND, s);
        if (s < NUM_SYMS) counted++;
      end
      put(($urandom_range(0, 7) == 0) ? CMD_NEXT : CMD_FIRST, query_sym());
      counted++;
      repeat ($urandom_range(0, 7)) begin
        put(CMD_NEXT, query_sym());
        counted++;
      end
    end

    // Closing searches, an invalid step, and a clear
    put(CMD_FIRST, SYM_T);
    put(CMD_NEXT, SYM_A);
    put(CMD_NEXT, SYM_G);
    put(CMD_FIRST, 3'($urandom_range(SYM_A, SYM_T)));
    put(CMD_NEXT, 3'($urandom_range(SYM_A, SYM_T)));
    put(CMD_NEXT, SYM_INV_7);
    put(CMD_CLEAR, SYM_INV_7);

    // Reset, then let the driver run
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    wait (cmd_q.size() == 0 && !in_tvalid);
    wait (interval_q.size() == 0);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (!failed && interval_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
